FILE: rtl/rrfr_pkg.sv
// Package for the reader response frame receiver.
// Holds the shared codes, limits and the result record; no dependencies.
`default_nettype none

package rrfr_pkg;

  // Largest parameter field that a frame may announce.
  localparam int unsigned MaxParamBytes = 256;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LengthW = 16;

  // Input operation codes.
  localparam logic OpByte    = 1'b0;
  localparam logic OpTimeout = 1'b1;

  // Configuration register indexes.
  localparam logic CfgHeader  = 1'b0;
  localparam logic CfgTrailer = 1'b1;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StChecksum = 3'd1,
    StBadEnd   = 3'd2,
    StTooLong  = 3'd3,
    StTimeout  = 3'd4
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] header_value;
    logic [ByteW-1:0] trailer_value;
  } cfg_t;

  typedef struct packed {
    logic               is_status;
    logic [ByteW-1:0]   payload_byte;
    logic [ByteW-1:0]   payload_index;
    logic [ByteW-1:0]   frame_type;
    logic [ByteW-1:0]   command_code;
    logic [LengthW-1:0] param_length;
    status_e            status;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/rrfr_cfg_regs.sv
// Configuration registers of the frame receiver: header and trailer values.
// Depends on rrfr_pkg.
`default_nettype none

module rrfr_cfg_regs
  import rrfr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic             cfg_index_i,
  input  wire logic [ByteW-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHeader:  cfg_d.header_value  = cfg_data_i;
        CfgTrailer: cfg_d.trailer_value = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_value  <= 8'hAA;
      cfg_q.trailer_value <= 8'hDD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/rrfr_parser.sv
// Frame parser: phase machine, held header fields and running checksum.
// Produces at most one result per accepted byte. Depends on rrfr_pkg.
`default_nettype none

module rrfr_parser
  import rrfr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic             operation_i,
  input  wire logic [ByteW-1:0] rx_byte_i,
  input  wire cfg_t             cfg_i,
  output logic                  res_valid_o,
  output result_t               res_o
);

  typedef enum logic [2:0] {
    PhHunt, PhType, PhCmd, PhLenHi, PhLenLo, PhParam, PhCheck, PhEnd
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [LengthW-1:0]   byte_count_q, byte_count_d;
  logic [ByteW-1:0]     held_type_q, held_type_d;
  logic [ByteW-1:0]     held_command_q, held_command_d;
  logic [LengthW-1:0]   held_length_q, held_length_d;
  logic [ByteW-1:0]     running_sum_q, running_sum_d;
  logic [LengthW-1:0]   count_inc;
  logic                 res_valid;
  logic                 res_is_status;
  logic [ByteW-1:0]     res_byte;
  logic [ByteW-1:0]     res_index;
  status_e              res_status;

  assign count_inc = byte_count_q + LengthW'(1);

  always_comb begin
    phase_d        = phase_q;
    byte_count_d   = byte_count_q;
    held_type_d    = held_type_q;
    held_command_d = held_command_q;
    held_length_d  = held_length_q;
    running_sum_d  = running_sum_q;
    res_valid      = 1'b0;
    res_is_status  = 1'b0;
    res_byte       = '0;
    res_index      = '0;
    res_status     = StOk;

    if (accept_i) begin
      if (operation_i == OpTimeout) begin
        // A timeout closes an open frame; while hunting it is ignored.
        if (phase_q != PhHunt) begin
          res_valid     = 1'b1;
          res_is_status = 1'b1;
          res_status    = StTimeout;
          phase_d       = PhHunt;
        end
      end else begin
        unique case (phase_q)
          PhHunt: begin
            if (rx_byte_i == cfg_i.header_value) begin
              held_type_d    = '0;
              held_command_d = '0;
              held_length_d  = '0;
              running_sum_d  = '0;
              byte_count_d   = '0;
              phase_d        = PhType;
            end
          end
          PhType: begin
            held_type_d   = rx_byte_i;
            running_sum_d = running_sum_q + rx_byte_i;
            phase_d       = PhCmd;
          end
          PhCmd: begin
            held_command_d = rx_byte_i;
            running_sum_d  = running_sum_q + rx_byte_i;
            phase_d        = PhLenHi;
          end
          PhLenHi: begin
            held_length_d = {rx_byte_i, 8'h00};
            running_sum_d = running_sum_q + rx_byte_i;
            phase_d       = PhLenLo;
          end
          PhLenLo: begin
            held_length_d = {held_length_q[LengthW-1:ByteW], rx_byte_i};
            running_sum_d = running_sum_q + rx_byte_i;
            byte_count_d  = '0;
            if (held_length_d > LengthW'(MaxParamBytes)) begin
              res_valid     = 1'b1;
              res_is_status = 1'b1;
              res_status    = StTooLong;
              phase_d       = PhHunt;
            end else if (held_length_d == '0) begin
              phase_d = PhCheck;
            end else begin
              phase_d = PhParam;
            end
          end
          PhParam: begin
            res_valid     = 1'b1;
            res_byte      = rx_byte_i;
            res_index     = byte_count_q[ByteW-1:0];
            running_sum_d = running_sum_q + rx_byte_i;
            byte_count_d  = count_inc;
            if (count_inc >= held_length_q) begin
              phase_d = PhCheck;
            end
          end
          PhCheck: begin
            // Zero here means the received checksum matched.
            running_sum_d = running_sum_q ^ rx_byte_i;
            phase_d       = PhEnd;
          end
          PhEnd: begin
            res_valid     = 1'b1;
            res_is_status = 1'b1;
            if (rx_byte_i != cfg_i.trailer_value) begin
              res_status = StBadEnd;
            end else if (running_sum_q != '0) begin
              res_status = StChecksum;
            end else begin
              res_status = StOk;
            end
            phase_d = PhHunt;
          end
          default: phase_d = PhHunt;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhHunt;
      byte_count_q   <= '0;
      held_type_q    <= '0;
      held_command_q <= '0;
      held_length_q  <= '0;
      running_sum_q  <= '0;
    end else begin
      phase_q        <= phase_d;
      byte_count_q   <= byte_count_d;
      held_type_q    <= held_type_d;
      held_command_q <= held_command_d;
      held_length_q  <= held_length_d;
      running_sum_q  <= running_sum_d;
    end
  end

  assign res_valid_o         = res_valid;
  assign res_o.is_status     = res_is_status;
  assign res_o.payload_byte  = res_byte;
  assign res_o.payload_index = res_index;
  assign res_o.frame_type    = held_type_d;
  assign res_o.command_code  = held_command_d;
  assign res_o.param_length  = held_length_d;
  assign res_o.status        = res_status;
  assign res_o.last          = res_is_status;

`ifndef SYNTHESIS
  // The parameter counter never reaches the announced length inside the field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhParam |-> byte_count_q < held_length_q)
    else $error("parameter count overran the announced length");

  // A timeout while hunting must not produce a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && operation_i == OpTimeout && phase_q == PhHunt) |-> !res_valid)
    else $error("result produced for a timeout while hunting");

  // Parameter results carry ok status and come only from the parameter field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_is_status) |-> (res_status == StOk && phase_q == PhParam))
    else $error("parameter result outside the parameter field");

  // Every status result returns the machine to hunting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_is_status) |=> phase_q == PhHunt)
    else $error("status result did not end the frame");
`endif

endmodule

`default_nettype wire

FILE: rtl/rrfr_out_reg.sv
// Result register of the frame receiver with its valid/ready handshake.
// Depends on rrfr_pkg.
`default_nettype none

module rrfr_out_reg
  import rrfr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  input  wire logic    out_ready_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // A new byte may enter whenever the held result is gone or leaves now.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // A result is never written over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!valid_q || out_ready_i))
    else $error("result overwritten before transfer");
`endif

endmodule

`default_nettype wire

FILE: rtl/reader_response_frame_receiver.sv
// Top level of the reader response frame receiver.
// Instantiates rrfr_cfg_regs, rrfr_parser and rrfr_out_reg; depends on rrfr_pkg.
//
//   Channel  Direction  Handshake                Content
//   in       sink       in_valid_i / in_ready_o  operation_i, rx_byte_i
//   out      source     out_valid_o/out_ready_i  one parameter byte or frame status
//   cfg      sink       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each input transfer is handled at the edge that accepts it: the parser
// updates its state and the result, if any, is written into the result
// register at that edge, so it shows on the output in the next cycle.
// Sustained rate is one byte per cycle; only the single result register
// limits it, and a byte is taken whenever that register is empty or emptying.
// Reset puts the parser into header hunting and loads header 0xAA and
// trailer 0xDD; no clearing pass is needed.
// Configuration writes are always accepted and take effect once registered.
`default_nettype none

module reader_response_frame_receiver
  import rrfr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Byte input.
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               operation_i,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  // Result output.
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    is_status_o,
  output logic [ByteW-1:0]        payload_byte_o,
  output logic [ByteW-1:0]        payload_index_o,
  output logic [ByteW-1:0]        frame_type_o,
  output logic [ByteW-1:0]        command_code_o,
  output logic [LengthW-1:0]      param_length_o,
  output logic [2:0]              status_o,
  output logic                    last_o,
  // Configuration writes.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_index_i,
  input  wire logic [ByteW-1:0]   cfg_data_i
);

  cfg_t    cfg;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t res_q;

  // The register file never stalls a write.
  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  rrfr_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The parser sees every accepted byte; bytes of an open frame that give no
  // result still advance the phase machine and the checksum.
  rrfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .operation_i (operation_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rrfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .res_o       (res_q)
  );

  assign is_status_o     = res_q.is_status;
  assign payload_byte_o  = res_q.payload_byte;
  assign payload_index_o = res_q.payload_index;
  assign frame_type_o    = res_q.frame_type;
  assign command_code_o  = res_q.command_code;
  assign param_length_o  = res_q.param_length;
  assign status_o        = 3'(res_q.status);
  assign last_o          = res_q.last;

endmodule

`default_nettype wire
